/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the profile valley separator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define PVSD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be true outside reset.
`define PVSD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define PVSD_ASSERT(lbl, clk, rstn, prop, msg)
`define PVSD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* hw/rtl/pvsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvsd_pkg
// Types and constants shared by the profile valley separator detector.
// ----------------------------------------------------------------------------
package pvsd_pkg;

  localparam int SAMPLE_BITS_DEF        = 24;
  localparam int MAX_PROFILE_LENGTH_DEF = 4096;
  localparam int ALPHA_W                = 16;
  localparam int FRAC_BITS              = 16;
  localparam int INDEX_W                = 12;
  localparam int OUT_TDATA_W            = ((INDEX_W + 7) / 8) * 8;
  localparam int OUTQ_DEPTH             = 4;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

  // One result transaction.
  typedef struct packed {
    logic [INDEX_W-1:0] sep_index;
    logic               is_sep;
    logic               eop;
  } result_t;

  // Qualifiers of one derivative event.
  typedef struct packed {
    logic last_item;  // event belongs to the final sample of the profile
    logic flush;      // closing derivative of the profile
  } ev_flags_t;

endpackage

/* hw/rtl/pvsd_deriv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvsd_deriv
// Sample history and derivative former; issues one derivative event a cycle unless ev_ready_i holds it back.
// ----------------------------------------------------------------------------
module pvsd_deriv #(
  parameter int  SAMPLE_BITS        = pvsd_pkg::SAMPLE_BITS_DEF,
  parameter int  MAX_PROFILE_LENGTH = pvsd_pkg::MAX_PROFILE_LENGTH_DEF,
  localparam int IDX_W              = $clog2(MAX_PROFILE_LENGTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  output logic                      s_ready_o,
  input  logic [SAMPLE_BITS-1:0]    sample_i,
  input  logic                      last_i,
  output logic                      ev_valid_o,
  input  logic                      ev_ready_i,
  output logic signed [SAMPLE_BITS:0] ev_diff_o,
  output logic [IDX_W-1:0]          ev_pos_o,
  output pvsd_pkg::ev_flags_t       ev_flags_o
);
  import pvsd_pkg::*;

  localparam logic [IDX_W-1:0] CAP = IDX_W'(MAX_PROFILE_LENGTH - 1);

  logic [SAMPLE_BITS-1:0] prev_q, prev_d, older_q, older_d;
  logic [IDX_W-1:0]       count_q, count_d;
  logic                   ev_valid_q, ev_valid_d;
  logic                   flush_pend_q, flush_pend_d;

  logic signed [SAMPLE_BITS:0] ev_diff_q, ev_diff_d;
  logic [IDX_W-1:0]            ev_pos_q, ev_pos_d;
  ev_flags_t                   ev_flags_q, ev_flags_d;
  logic signed [SAMPLE_BITS:0] flush_diff_q, flush_diff_d;
  logic [IDX_W-1:0]            flush_pos_q, flush_pos_d;

  logic                        slot_free;
  logic                        accept;
  logic signed [SAMPLE_BITS:0] samp_ext, prev_ext, older_ext;
  logic signed [SAMPLE_BITS:0] d_inner, d_flush;

  assign slot_free = !ev_valid_q || ev_ready_i;
  assign s_ready_o = slot_free && !flush_pend_q;
  assign accept    = s_valid_i && s_ready_o;

  assign samp_ext  = $signed({1'b0, sample_i});
  assign prev_ext  = $signed({1'b0, prev_q});
  assign older_ext = $signed({1'b0, older_q});

  // The second sample still has only a one-sided difference behind it.
  assign d_inner = (count_q == IDX_W'(1)) ? (samp_ext - prev_ext) : (samp_ext - older_ext);
  assign d_flush = samp_ext - prev_ext;

  always_comb begin
    prev_d       = prev_q;
    older_d      = older_q;
    count_d      = count_q;
    flush_pend_d = flush_pend_q;
    flush_diff_d = flush_diff_q;
    flush_pos_d  = flush_pos_q;
    ev_valid_d   = ev_valid_q && !ev_ready_i;
    ev_diff_d    = ev_diff_q;
    ev_pos_d     = ev_pos_q;
    ev_flags_d   = ev_flags_q;

    if (flush_pend_q && slot_free) begin
      ev_valid_d           = 1'b1;
      ev_diff_d            = flush_diff_q;
      ev_pos_d             = flush_pos_q;
      ev_flags_d.last_item = 1'b1;
      ev_flags_d.flush     = 1'b1;
      flush_pend_d         = 1'b0;
    end else if (accept) begin
      if (count_q != '0) begin
        ev_valid_d           = 1'b1;
        ev_diff_d            = d_inner;
        ev_pos_d             = count_q - IDX_W'(1);
        ev_flags_d.last_item = last_i;
        ev_flags_d.flush     = 1'b0;
        if (last_i) begin
          flush_pend_d = 1'b1;
          flush_diff_d = d_flush;
          flush_pos_d  = count_q;
        end
      end else if (last_i) begin
        // A single-sample profile has a zero derivative at position zero.
        ev_valid_d           = 1'b1;
        ev_diff_d            = '0;
        ev_pos_d             = '0;
        ev_flags_d.last_item = 1'b1;
        ev_flags_d.flush     = 1'b1;
      end

      if (last_i) begin
        prev_d  = '0;
        older_d = '0;
        count_d = '0;
      end else begin
        older_d = prev_q;
        prev_d  = sample_i;
        if (count_q < CAP) begin
          count_d = count_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      older_q      <= '0;
      count_q      <= '0;
      ev_valid_q   <= 1'b0;
      flush_pend_q <= 1'b0;
    end else begin
      prev_q       <= prev_d;
      older_q      <= older_d;
      count_q      <= count_d;
      ev_valid_q   <= ev_valid_d;
      flush_pend_q <= flush_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_diff_q    <= ev_diff_d;
    ev_pos_q     <= ev_pos_d;
    ev_flags_q   <= ev_flags_d;
    flush_diff_q <= flush_diff_d;
    flush_pos_q  <= flush_pos_d;
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_diff_o  = ev_diff_q;
  assign ev_pos_o   = ev_pos_q;
  assign ev_flags_o = ev_flags_q;

endmodule

/* hw/rtl/pvsd_ema.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvsd_ema
// Exponential moving average of the slope and separator decision.
// ----------------------------------------------------------------------------
module pvsd_ema #(
  parameter int  SAMPLE_BITS        = pvsd_pkg::SAMPLE_BITS_DEF,
  parameter int  MAX_PROFILE_LENGTH = pvsd_pkg::MAX_PROFILE_LENGTH_DEF,
  localparam int IDX_W              = $clog2(MAX_PROFILE_LENGTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pvsd_pkg::ALPHA_W-1:0]  cfg_wdata_i,
  input  logic                          ev_valid_i,
  output logic                          ev_ready_o,
  input  logic signed [SAMPLE_BITS:0]   ev_diff_i,
  input  logic [IDX_W-1:0]              ev_pos_i,
  input  pvsd_pkg::ev_flags_t           ev_flags_i,
  input  logic                          q_room_i,
  output logic [1:0]                    push_n_o,
  output pvsd_pkg::result_t             push0_o,
  output pvsd_pkg::result_t             push1_o
);
  import pvsd_pkg::*;

  localparam int AVG_W  = SAMPLE_BITS + 18;
  localparam int DIFF_W = AVG_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;

  logic [ALPHA_W-1:0]      alpha_q;
  logic signed [AVG_W-1:0] avg_q, avg_d;
  logic                    rising_q, rising_d;
  logic                    neg_seen_q, neg_seen_d;
  logic [IDX_W-1:0]        lni_q, lni_d;
  logic                    pend_valid_q, pend_valid_d;
  logic [INDEX_W-1:0]      pend_idx_q, pend_idx_d;

  logic                     take;
  logic signed [AVG_W-1:0]  target;
  logic signed [DIFF_W-1:0] diff, step, sum;
  logic signed [PROD_W-1:0] prod;
  logic signed [AVG_W-1:0]  avg_upd;
  logic                     is_pos, is_neg, emit;
  logic [INDEX_W-1:0]       sep_idx;

  assign ev_ready_o = q_room_i;
  assign take       = ev_valid_i && q_room_i;

  assign target = $signed({{(AVG_W - SAMPLE_BITS - 1 - FRAC_BITS){ev_diff_i[SAMPLE_BITS]}},
                           ev_diff_i, {FRAC_BITS{1'b0}}});
  assign diff   = DIFF_W'(target) - DIFF_W'(avg_q);
  assign prod   = PROD_W'(diff) * PROD_W'($signed({1'b0, alpha_q}));
  // The arithmetic shift drops the fraction towards minus infinity.
  assign step   = DIFF_W'(prod >>> FRAC_BITS);
  assign sum    = DIFF_W'(avg_q) + step;
  assign avg_upd = (ev_pos_i == '0) ? target : AVG_W'(sum);

  assign is_neg  = avg_upd[AVG_W-1];
  assign is_pos  = !avg_upd[AVG_W-1] && (avg_upd != '0);
  assign emit    = is_pos && !rising_q;
  assign sep_idx = neg_seen_q ? INDEX_W'(lni_q) : INDEX_W'(ev_pos_i);

  always_comb begin
    avg_d        = avg_q;
    rising_d     = rising_q;
    neg_seen_d   = neg_seen_q;
    lni_d        = lni_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    if (take) begin
      if (ev_flags_i.flush) begin
        avg_d        = '0;
        rising_d     = 1'b0;
        neg_seen_d   = 1'b0;
        lni_d        = '0;
        pend_valid_d = 1'b0;
      end else begin
        avg_d = avg_upd;
        if (emit) begin
          rising_d = 1'b1;
        end else if (is_neg) begin
          lni_d      = ev_pos_i;
          neg_seen_d = 1'b1;
          rising_d   = 1'b0;
        end
        // A separator found on the final sample waits until the flush
        // decides whether it closes the profile.
        if (ev_flags_i.last_item) begin
          pend_valid_d = emit;
          pend_idx_d   = sep_idx;
        end
      end
    end
  end

  always_comb begin
    push_n_o = 2'd0;
    push0_o  = '0;
    push1_o  = '0;
    if (take) begin
      if (ev_flags_i.flush) begin
        if (pend_valid_q) begin
          push0_o = '{sep_index: pend_idx_q, is_sep: 1'b1, eop: !emit};
          if (emit) begin
            push1_o  = '{sep_index: sep_idx, is_sep: 1'b1, eop: 1'b1};
            push_n_o = 2'd2;
          end else begin
            push_n_o = 2'd1;
          end
        end else if (emit) begin
          push0_o  = '{sep_index: sep_idx, is_sep: 1'b1, eop: 1'b1};
          push_n_o = 2'd1;
        end else begin
          push0_o  = '{sep_index: '0, is_sep: 1'b0, eop: 1'b1};
          push_n_o = 2'd1;
        end
      end else if (!ev_flags_i.last_item && emit) begin
        push0_o  = '{sep_index: sep_idx, is_sep: 1'b1, eop: 1'b0};
        push_n_o = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q      <= ALPHA_RESET;
      avg_q        <= '0;
      rising_q     <= 1'b0;
      neg_seen_q   <= 1'b0;
      lni_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
      avg_q        <= avg_d;
      rising_q     <= rising_d;
      neg_seen_q   <= neg_seen_d;
      lni_q        <= lni_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
  end

endmodule

/* hw/rtl/pvsd_outq.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pvsd_outq
// Small result queue: up to two in a cycle, one out when m_ready_i is high.
// ----------------------------------------------------------------------------
module pvsd_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_n_i,
  input  pvsd_pkg::result_t push0_i,
  input  pvsd_pkg::result_t push1_i,
  output logic              room_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output pvsd_pkg::result_t m_data_o
);
  import pvsd_pkg::*;

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  result_t            mem_q [OUTQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               pop;

  assign m_valid_o = (count_q != '0);
  assign pop       = m_valid_o && m_ready_i;
  assign m_data_o  = mem_q[rd_ptr_q];
  // Room is judged on the registered fill so that a double push always fits.
  assign room_o    = (count_q <= CNT_W'(OUTQ_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    case (push_n_i)
      2'd1: begin
        mem_q[wr_ptr_q] <= push0_i;
      end
      2'd2: begin
        mem_q[wr_ptr_q]                <= push0_i;
        mem_q[wr_ptr_q + PTR_W'(1)]    <= push1_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n_i);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + CNT_W'(push_n_i) - CNT_W'(pop);
    end
  end

  `PVSD_ASSERT_NEVER(a_fill_in_range, clk_i, rst_ni, count_q > CNT_W'(OUTQ_DEPTH), "result queue overfilled")
  `PVSD_ASSERT(a_push_with_room, clk_i, rst_ni, (push_n_i != 2'd0) |-> room_o, "result pushed without room")
  `PVSD_ASSERT(a_double_push_closes, clk_i, rst_ni, (push_n_i == 2'd2) |-> (push1_i.eop && push1_i.is_sep && !push0_i.eop), "double push does not close the profile")
  `PVSD_ASSERT(a_drain_empty, clk_i, rst_ni, (pop && push_n_i == 2'd0 && count_q == CNT_W'(1)) |=> !m_valid_o, "queue not empty after last pop")

endmodule

/* hw/rtl/profile_valley_separator_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// profile_valley_separator_detector
// Finds valley separators in a projection profile from the smoothed slope.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Payload
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | tdata: sample; tlast: final sample of profile
//  m_axis    | out       | tdata: separator_index; tuser: is_separator;
//            |           | tlast: end_of_profile
//  cfg       | in        | cfg_wdata_i: alpha (Q0.16), written when cfg_we_i
//
//  One sample is taken per cycle while s_axis_tready is high. The final
//  sample of a profile with two or more samples also issues a closing
//  derivative, which passes through the same averaging multiplier after
//  the inner one. A separator passes from the derivative register through
//  the averaging logic into the result queue before it is offered; the
//  closing results take the same path. Up to four results queue.
//  Asynchronous reset clears the control state; alpha returns to 6554.
//  s_axis_tready drops in the cycle that issues a closing derivative, and
//  while a derivative waits because the result queue holds more than two.
// ----------------------------------------------------------------------------
module profile_valley_separator_detector #(
  parameter int  SAMPLE_BITS        = pvsd_pkg::SAMPLE_BITS_DEF,
  parameter int  MAX_PROFILE_LENGTH = pvsd_pkg::MAX_PROFILE_LENGTH_DEF,
  localparam int S_TDATA_W          = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pvsd_pkg::ALPHA_W-1:0]        cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [S_TDATA_W-1:0]                s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pvsd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [11:0] separator_index
  output logic                                m_axis_tuser,  // [0] is_separator
  output logic                                m_axis_tlast
);
  import pvsd_pkg::*;

  localparam int IDX_W = $clog2(MAX_PROFILE_LENGTH);

  logic                        ev_valid, ev_ready;
  logic signed [SAMPLE_BITS:0] ev_diff;
  logic [IDX_W-1:0]            ev_pos;
  ev_flags_t                   ev_flags;
  logic                        q_room;
  logic [1:0]                  push_n;
  result_t                     push0, push1;
  result_t                     m_data;

  pvsd_deriv #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .MAX_PROFILE_LENGTH(MAX_PROFILE_LENGTH)
  ) u_deriv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sample_i  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .last_i    (s_axis_tlast),
    .ev_valid_o(ev_valid),
    .ev_ready_i(ev_ready),
    .ev_diff_o (ev_diff),
    .ev_pos_o  (ev_pos),
    .ev_flags_o(ev_flags)
  );

  pvsd_ema #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .MAX_PROFILE_LENGTH(MAX_PROFILE_LENGTH)
  ) u_ema (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .ev_valid_i (ev_valid),
    .ev_ready_o (ev_ready),
    .ev_diff_i  (ev_diff),
    .ev_pos_i   (ev_pos),
    .ev_flags_i (ev_flags),
    .q_room_i   (q_room),
    .push_n_o   (push_n),
    .push0_o    (push0),
    .push1_o    (push1)
  );

  pvsd_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (push0),
    .push1_i  (push1),
    .room_o   (q_room),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_data)
  );

  assign m_axis_tdata = OUT_TDATA_W'(m_data.sep_index);
  assign m_axis_tuser = m_data.is_sep;
  assign m_axis_tlast = m_data.eop;

endmodule
